// File: rtl/mlss_pkg.sv
// Package for the lock motor stall sequencer: widths, codes and word types.
package mlss_pkg;

  // Field widths
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned TIMER_BITS  = 16;
  localparam int unsigned RUN_BITS    = 8;
  localparam int unsigned TRIES_BITS  = 4;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] THRESH_RST  = SAMPLE_BITS'(2048);
  localparam logic [RUN_BITS-1:0]    STALL_RST   = RUN_BITS'(20);
  localparam logic [TIMER_BITS-1:0]  BLANK_RST   = TIMER_BITS'(2000);
  localparam logic [TIMER_BITS-1:0]  TIMEOUT_RST = TIMER_BITS'(20000);
  localparam logic [TIMER_BITS-1:0]  PAUSE_RST   = TIMER_BITS'(1000);
  localparam logic [TRIES_BITS-1:0]  TRIES_RST   = TRIES_BITS'(2);

  // Command codes
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_LOCK   = 2'd1,
    MODE_UNLOCK = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  // Sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BLANK = 2'd1,
    PH_RUN   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_e;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESH  = 3'd0,
    REG_STALL   = 3'd1,
    REG_BLANK   = 3'd2,
    REG_TIMEOUT = 3'd3,
    REG_PAUSE   = 3'd4,
    REG_TRIES   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic                   door_closed;
  } in_word_t;

  typedef struct packed {
    logic drive_lock;
    logic drive_unlock;
    logic busy_res;
    logic locked;
    logic stall_seen;
    logic done_res;
  } out_word_t;

  // Saturating timer increment
  function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] t);
    tick_up = (&t) ? t : t + TIMER_BITS'(1);
  endfunction

endpackage

// File: rtl/motor_lock_stall_sequencer.sv
// Lock motor stall sequencer: input register, one step of phase logic, result register.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid_i, in_stall_o, in_data_i         | in
//   out      | out_valid_o, out_stall_i, out_data_o      | out
//   cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i/data| in
//
// One word per cycle while the output is not stalled; a taken word passes through the input
// register, then the result register, and leaves from the result register.
// All sequencer state moves as the word passes from the input register to the result register.
// Reset clears the sequencer to idle, unlocked, and loads register defaults.
// A stalled output holds its word; the input stalls only when both stages are full
// and the output is stalled.
module motor_lock_stall_sequencer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mlss_pkg::in_word_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output mlss_pkg::out_word_t                   out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mlss_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [mlss_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  localparam int unsigned SB = mlss_pkg::SAMPLE_BITS;
  localparam int unsigned TB = mlss_pkg::TIMER_BITS;
  localparam int unsigned RB = mlss_pkg::RUN_BITS;
  localparam int unsigned AB = mlss_pkg::TRIES_BITS;

  // Configuration registers
  logic [SB-1:0] thresh_q;
  logic [RB-1:0] stall_ticks_q;
  logic [TB-1:0] blank_q, timeout_q, pause_q;
  logic [AB-1:0] tries_q;

  // Sequencer state
  mlss_pkg::phase_e phase_q, phase_d;
  logic             dir_q, dir_d;
  logic [TB-1:0]    timer_q, timer_d;
  logic [RB-1:0]    run_q, run_d;
  logic [AB-1:0]    att_q, att_d;
  logic             locked_q, locked_d;

  // Pipeline stages
  logic                 in_vld_q;
  mlss_pkg::in_word_t   in_q;
  logic                 out_vld_q;
  mlss_pkg::out_word_t  out_q, res_d;
  logic                 advance, take_in;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;
  assign take_in     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      <= mlss_pkg::THRESH_RST;
      stall_ticks_q <= mlss_pkg::STALL_RST;
      blank_q       <= mlss_pkg::BLANK_RST;
      timeout_q     <= mlss_pkg::TIMEOUT_RST;
      pause_q       <= mlss_pkg::PAUSE_RST;
      tries_q       <= mlss_pkg::TRIES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mlss_pkg::REG_THRESH:  thresh_q      <= cfg_data_i[SB-1:0];
        mlss_pkg::REG_STALL:   stall_ticks_q <= cfg_data_i[RB-1:0];
        mlss_pkg::REG_BLANK:   blank_q       <= cfg_data_i[TB-1:0];
        mlss_pkg::REG_TIMEOUT: timeout_q     <= cfg_data_i[TB-1:0];
        mlss_pkg::REG_PAUSE:   pause_q       <= cfg_data_i[TB-1:0];
        mlss_pkg::REG_TRIES:   tries_q       <= cfg_data_i[AB-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the sequencer, phases fall through within the tick
  always_comb begin
    logic [RB-1:0] need_stall;
    logic [AB-1:0] need_tries;
    logic          drive, stall, done;
    need_stall = (stall_ticks_q == '0) ? RB'(1) : stall_ticks_q;
    need_tries = (tries_q == '0) ? AB'(1) : tries_q;
    drive    = 1'b0;
    stall    = 1'b0;
    done     = 1'b0;
    phase_d  = phase_q;
    dir_d    = dir_q;
    timer_d  = timer_q;
    run_d    = run_q;
    att_d    = att_q;
    locked_d = locked_q;

    // Command decode while idle; door open on lock skips the motor
    if (phase_d == mlss_pkg::PH_IDLE) begin
      if (in_q.mode == mlss_pkg::MODE_LOCK && !in_q.door_closed) begin
        locked_d = 1'b1;
        done     = 1'b1;
      end else if (in_q.mode == mlss_pkg::MODE_LOCK ||
                   in_q.mode == mlss_pkg::MODE_UNLOCK) begin
        dir_d   = (in_q.mode == mlss_pkg::MODE_LOCK);
        phase_d = mlss_pkg::PH_BLANK;
        timer_d = '0;
        run_d   = '0;
        att_d   = '0;
      end
    end

    // Blanking: drive, ignore current
    if (phase_d == mlss_pkg::PH_BLANK) begin
      if (timer_d >= blank_q) begin
        phase_d = mlss_pkg::PH_RUN;
        timer_d = '0;
        run_d   = '0;
      end else begin
        drive   = 1'b1;
        timer_d = mlss_pkg::tick_up(timer_d);
      end
    end

    // Run: count pushing ticks, stop on stall or timeout
    if (phase_d == mlss_pkg::PH_RUN) begin
      if (in_q.current_sample >= thresh_q) begin
        run_d = (&run_d) ? run_d : run_d + RB'(1);
      end else begin
        run_d = '0;
      end
      if (run_d >= need_stall) begin
        stall   = 1'b1;
        phase_d = mlss_pkg::PH_PAUSE;
        timer_d = '0;
      end else if (timer_d >= timeout_q) begin
        phase_d = mlss_pkg::PH_PAUSE;
        timer_d = '0;
      end else begin
        drive   = 1'b1;
        timer_d = mlss_pkg::tick_up(timer_d);
      end
    end

    // Pause: relays off, then next attempt or finish
    if (phase_d == mlss_pkg::PH_PAUSE) begin
      timer_d = mlss_pkg::tick_up(timer_d);
      if (timer_d >= pause_q) begin
        att_d = att_d + AB'(1);
        if (att_d == '0 || att_d >= need_tries) begin
          phase_d  = mlss_pkg::PH_IDLE;
          locked_d = dir_d;
          done     = 1'b1;
        end else begin
          phase_d = mlss_pkg::PH_BLANK;
        end
        timer_d = '0;
        run_d   = '0;
      end
    end

    res_d.drive_lock   = drive && dir_d;
    res_d.drive_unlock = drive && !dir_d;
    res_d.busy_res     = (phase_d != mlss_pkg::PH_IDLE);
    res_d.locked       = locked_d;
    res_d.stall_seen   = stall;
    res_d.done_res     = done;
  end

  // State and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mlss_pkg::PH_IDLE;
      dir_q     <= 1'b0;
      timer_q   <= '0;
      run_q     <= '0;
      att_q     <= '0;
      locked_q  <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q  <= phase_d;
        dir_q    <= dir_d;
        timer_q  <= timer_d;
        run_q    <= run_d;
        att_q    <= att_d;
        locked_q <= locked_d;
      end
      if (take_in) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

`ifndef SYNTH
  // Relays are never both on
  a_relay_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.drive_lock && out_q.drive_unlock))
    else $error("both relays driven");

  // A finished sequence leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done while still busy");

  // Drive only happens inside a sequence
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.drive_lock || out_q.drive_unlock) |-> out_q.busy_res)
    else $error("drive while idle");

  // Locked flag moves only with a done word
  a_lock_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q != $past(locked_q) |-> out_vld_q && out_q.done_res)
    else $error("locked flag changed without done");

  // Idle state carries no attempt in progress on the output
  a_idle_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) && phase_q == mlss_pkg::PH_IDLE |-> !out_q.busy_res)
    else $error("busy reported while idle");
`endif

endmodule

// File: verif/mlss_checker.sv
// Checker for the lock motor stall sequencer: tracks accepted ticks, predicts and compares words.
module mlss_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  mlss_pkg::in_word_t                  in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  mlss_pkg::out_word_t                 out_data_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [mlss_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [mlss_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output int                                  pending_o,
  output int                                  fails_o,
  output int                                  dones_o,
  output int                                  stalls_o
);

  localparam int unsigned SB = mlss_pkg::SAMPLE_BITS;
  localparam int unsigned TB = mlss_pkg::TIMER_BITS;
  localparam int unsigned RB = mlss_pkg::RUN_BITS;
  localparam int unsigned AB = mlss_pkg::TRIES_BITS;

  // Register copies
  logic [SB-1:0] thresh_r;
  logic [RB-1:0] stall_need_r;
  logic [TB-1:0] blank_r;
  logic [TB-1:0] timeout_r;
  logic [TB-1:0] pause_r;
  logic [AB-1:0] tries_r;

  // Sequencer state copy
  mlss_pkg::phase_e seq_phase;
  logic             seq_dir;
  logic [TB-1:0]    seq_timer;
  logic [RB-1:0]    push_run;
  logic [AB-1:0]    tries_done;
  logic             lock_state;

  mlss_pkg::out_word_t motor_words_q[$];
  mlss_pkg::out_word_t oldest;
  int                  n_fail;
  int                  n_done;
  int                  n_stall;

  function automatic logic [TB-1:0] bump_timer(input logic [TB-1:0] t);
    return (&t) ? t : t + TB'(1);
  endfunction

  // One sample tick of the sequencer; updates the state copy and returns the word it shows
  function automatic mlss_pkg::out_word_t step_sequencer(input mlss_pkg::in_word_t w);
    mlss_pkg::out_word_t r;
    logic                drv;
    logic                hit;
    logic                fin;
    logic [RB-1:0]       need_run;
    logic [AB-1:0]       need_tries;
    drv = 1'b0;
    hit = 1'b0;
    fin = 1'b0;
    need_run   = (stall_need_r != '0) ? stall_need_r : RB'(1);
    need_tries = (tries_r != '0) ? tries_r : AB'(1);

    // Commands count only while idle; lock with the door open just sets the flag
    if (seq_phase == mlss_pkg::PH_IDLE) begin
      if (w.mode == mlss_pkg::MODE_LOCK && !w.door_closed) begin
        lock_state = 1'b1;
        fin = 1'b1;
      end else if (w.mode == mlss_pkg::MODE_LOCK || w.mode == mlss_pkg::MODE_UNLOCK) begin
        seq_dir    = (w.mode == mlss_pkg::MODE_LOCK);
        seq_phase  = mlss_pkg::PH_BLANK;
        seq_timer  = '0;
        push_run   = '0;
        tries_done = '0;
      end
    end

    // Blanking: drive, ignore current
    if (seq_phase == mlss_pkg::PH_BLANK) begin
      if (seq_timer >= blank_r) begin
        seq_phase = mlss_pkg::PH_RUN;
        seq_timer = '0;
        push_run  = '0;
      end else begin
        drv = 1'b1;
        seq_timer = bump_timer(seq_timer);
      end
    end

    // Run: drive until stall or timeout
    if (seq_phase == mlss_pkg::PH_RUN) begin
      if (w.current_sample >= thresh_r)
        push_run = (&push_run) ? push_run : push_run + RB'(1);
      else
        push_run = '0;
      if (push_run >= need_run) begin
        hit = 1'b1;
        seq_phase = mlss_pkg::PH_PAUSE;
        seq_timer = '0;
      end else if (seq_timer >= timeout_r) begin
        seq_phase = mlss_pkg::PH_PAUSE;
        seq_timer = '0;
      end else begin
        drv = 1'b1;
        seq_timer = bump_timer(seq_timer);
      end
    end

    // Pause: relays off, then next attempt or finish
    if (seq_phase == mlss_pkg::PH_PAUSE) begin
      seq_timer = bump_timer(seq_timer);
      if (seq_timer >= pause_r) begin
        tries_done = tries_done + AB'(1);
        if (tries_done == '0 || tries_done >= need_tries) begin
          seq_phase  = mlss_pkg::PH_IDLE;
          lock_state = seq_dir;
          fin = 1'b1;
        end else begin
          seq_phase = mlss_pkg::PH_BLANK;
        end
        seq_timer = '0;
        push_run  = '0;
      end
    end

    r.drive_lock   = drv & seq_dir;
    r.drive_unlock = drv & ~seq_dir;
    r.busy_res     = (seq_phase != mlss_pkg::PH_IDLE);
    r.locked       = lock_state;
    r.stall_seen   = hit;
    r.done_res     = fin;
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic want, input logic got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_r     = mlss_pkg::THRESH_RST;
      stall_need_r = mlss_pkg::STALL_RST;
      blank_r      = mlss_pkg::BLANK_RST;
      timeout_r    = mlss_pkg::TIMEOUT_RST;
      pause_r      = mlss_pkg::PAUSE_RST;
      tries_r      = mlss_pkg::TRIES_RST;
      seq_phase    = mlss_pkg::PH_IDLE;
      seq_dir      = 1'b0;
      seq_timer    = '0;
      push_run     = '0;
      tries_done   = '0;
      lock_state   = 1'b0;
      motor_words_q.delete();
      n_fail  = 0;
      n_done  = 0;
      n_stall = 0;
      pending_o <= 0;
      fails_o   <= 0;
      dones_o   <= 0;
      stalls_o  <= 0;
    end else begin
      // Register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mlss_pkg::REG_THRESH:  thresh_r     = cfg_data_i[SB-1:0];
          mlss_pkg::REG_STALL:   stall_need_r = cfg_data_i[RB-1:0];
          mlss_pkg::REG_BLANK:   blank_r      = cfg_data_i[TB-1:0];
          mlss_pkg::REG_TIMEOUT: timeout_r    = cfg_data_i[TB-1:0];
          mlss_pkg::REG_PAUSE:   pause_r      = cfg_data_i[TB-1:0];
          mlss_pkg::REG_TRIES:   tries_r      = cfg_data_i[AB-1:0];
          default: ;
        endcase
      end

      // Accepted tick -> expected word
      if (in_valid_i && !in_stall_i)
        motor_words_q.push_back(step_sequencer(in_data_i));

      // Accepted word -> compare with oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (motor_words_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected word, expected none, actual %b", $time, out_data_i);
        end else begin
          oldest = motor_words_q.pop_front();
          check_field("drive_lock",   oldest.drive_lock,   out_data_i.drive_lock);
          check_field("drive_unlock", oldest.drive_unlock, out_data_i.drive_unlock);
          check_field("busy_res",     oldest.busy_res,     out_data_i.busy_res);
          check_field("locked",       oldest.locked,       out_data_i.locked);
          check_field("stall_seen",   oldest.stall_seen,   out_data_i.stall_seen);
          check_field("done_res",     oldest.done_res,     out_data_i.done_res);
          if (oldest.done_res) n_done++;
          if (oldest.stall_seen) n_stall++;
        end
      end

      pending_o <= motor_words_q.size();
      fails_o   <= n_fail;
      dones_o   <= n_done;
      stalls_o  <= n_stall;
    end
  end

endmodule

// File: verif/motor_lock_stall_sequencer_test.sv
// Testbench top for the lock motor stall sequencer: clock, reset, stimulus and verdict.
module motor_lock_stall_sequencer_test;

  localparam int TICK_TARGET = 1600;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_LIMIT  = 3000;
  localparam int SEQ_CAP     = 300;
  localparam int unsigned SB = mlss_pkg::SAMPLE_BITS;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid;
  logic                                in_stall;
  mlss_pkg::in_word_t                  in_data;
  logic                                out_valid;
  logic                                out_stall;
  mlss_pkg::out_word_t                 out_data;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [mlss_pkg::CFG_IDX_BITS-1:0]   cfg_index;
  logic [mlss_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  int pending;
  int fails;
  int seq_done;
  int stall_cnt;

  // Stimulus knobs and mirrors of the current setting
  int            src_gap_max;
  int            sink_gap_max;
  int            holds_asked;
  int            holds_served;
  int            ticks_sent;
  int            settings;
  int            idle_cycles;
  logic [SB-1:0] cur_thresh;
  int            cur_blank;
  int            cur_timeout;
  int            cur_pause;
  int            cur_tries;

  motor_lock_stall_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mlss_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fails_o     (fails),
    .dones_o     (seq_done),
    .stalls_o    (stall_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: ends the run if no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: random stall per word, one long hold on request
  initial begin : sink
    int gap;
    holds_served = 0;
    out_stall <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_asked > holds_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end else begin
        gap = $urandom_range(0, sink_gap_max);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // Offer one tick; returns at the edge that takes it, valid left high
  task automatic send_tick(input mlss_pkg::mode_e m, input logic [SB-1:0] s, input logic door);
    mlss_pkg::in_word_t w;
    int                 gap;
    w.mode = m;
    w.current_sample = s;
    w.door_closed = door;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input mlss_pkg::reg_idx_e idx,
                           input logic [mlss_pkg::CFG_DATA_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // New register setting; upper data bits beyond a register's width are random
  task automatic set_config(input int thr, input int stl, input int blank, input int tmo,
                            input int pause, input int tries);
    drain();
    write_reg(mlss_pkg::REG_THRESH,  {4'($urandom), SB'(thr)});
    write_reg(mlss_pkg::REG_STALL,   {8'($urandom), mlss_pkg::RUN_BITS'(stl)});
    write_reg(mlss_pkg::REG_BLANK,   mlss_pkg::TIMER_BITS'(blank));
    write_reg(mlss_pkg::REG_TIMEOUT, mlss_pkg::TIMER_BITS'(tmo));
    write_reg(mlss_pkg::REG_PAUSE,   mlss_pkg::TIMER_BITS'(pause));
    write_reg(mlss_pkg::REG_TRIES,   {12'($urandom), mlss_pkg::TRIES_BITS'(tries)});
    cfg_valid   <= 1'b0;
    cur_thresh  = SB'(thr);
    cur_blank   = blank;
    cur_timeout = tmo;
    cur_pause   = pause;
    cur_tries   = (tries == 0) ? 1 : tries;
    settings++;
  endtask

  // Current sample: pushing with the given percentage, boundary values now and then
  function automatic logic [SB-1:0] pick_sample(input int pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      return cur_thresh;
    if (roll < 10)
      return cur_thresh - SB'(1);
    if ($urandom_range(0, 99) < pct)
      return SB'($urandom_range(cur_thresh, 4095));
    if (cur_thresh == 0)
      return '0;
    return SB'($urandom_range(0, cur_thresh - 1));
  endfunction

  // Command then a run of ticks long enough for the sequence, with stray commands
  task automatic run_sequence(input mlss_pkg::mode_e cmd, input logic door);
    int              len;
    int              pct;
    mlss_pkg::mode_e m;
    len = cur_tries * (cur_blank + cur_timeout + cur_pause + 2) + $urandom_range(0, 3);
    if (len > SEQ_CAP) len = SEQ_CAP;
    case ($urandom_range(0, 3))
      0: pct = 0;
      1: pct = 30;
      2: pct = 85;
      default: pct = 100;
    endcase
    send_tick(cmd, pick_sample(pct), door);
    repeat (len) begin
      m = ($urandom_range(0, 99) < 4) ? mlss_pkg::mode_e'($urandom_range(0, 3))
                                       : mlss_pkg::MODE_NONE;
      send_tick(m, pick_sample(pct), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int              ph_no;
    int              n_seq;
    mlss_pkg::mode_e cmd;
    rst_ni      <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= mlss_pkg::REG_THRESH;
    cfg_data    <= '0;
    holds_asked = 0;
    src_gap_max = 10;
    sink_gap_max = 10;
    ticks_sent  = 0;
    settings    = 1;
    cur_thresh  = mlss_pkg::THRESH_RST;
    cur_blank   = mlss_pkg::BLANK_RST;
    cur_timeout = mlss_pkg::TIMEOUT_RST;
    cur_pause   = mlss_pkg::PAUSE_RST;
    cur_tries   = mlss_pkg::TRIES_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting, door-open lock, reserved mode, command while busy
    send_tick(mlss_pkg::MODE_LOCK,   12'hFFF, 1'b0);
    send_tick(mlss_pkg::MODE_RSVD,   12'h000, 1'b1);
    send_tick(mlss_pkg::MODE_UNLOCK, 12'hFFF, 1'b1);
    send_tick(mlss_pkg::MODE_LOCK,   12'h000, 1'b1);
    send_tick(mlss_pkg::MODE_NONE,   12'hFFF, 1'b0);

    // Change mid-sequence; zero stall ticks and zero attempts act as one
    set_config(4095, 0, 0, 3, 0, 0);
    send_tick(mlss_pkg::MODE_NONE,   12'hFFF, 1'b1);
    send_tick(mlss_pkg::MODE_LOCK,   12'hFFE, 1'b1);
    repeat (3) send_tick(mlss_pkg::MODE_NONE, 12'h000, 1'b0);
    send_tick(mlss_pkg::MODE_UNLOCK, 12'h000, 1'b0);
    send_tick(mlss_pkg::MODE_NONE,   12'hFFF, 1'b1);

    // Zero threshold: every sample pushes; zero timeout and pause
    set_config(0, 2, 1, 0, 0, 3);
    send_tick(mlss_pkg::MODE_LOCK, 12'h000, 1'b1);
    repeat (8) send_tick(mlss_pkg::MODE_NONE, 12'h000, 1'b1);
    send_tick(mlss_pkg::MODE_UNLOCK, 12'h555, 1'b0);
    repeat (5) send_tick(mlss_pkg::MODE_NONE, 12'hAAA, 1'b1);

    // Random phases of register settings and sequences
    ph_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      case (ph_no)
        2:       set_config(4095, 255, 65535, 65535, 65535, 15);
        4:       set_config(0, 255, 0, 400, 0, 1);
        6:       set_config($urandom_range(0, 4095), 1, 1, 2, 1, 15);
        default: set_config(($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 4095),
                            $urandom_range(0, 6), $urandom_range(0, 6),
                            $urandom_range(0, 12), $urandom_range(0, 5),
                            $urandom_range(0, 4));
      endcase
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      n_seq = (ph_no == 2 || ph_no == 4) ? 1 : $urandom_range(3, 8);

      // Result side holds off while ticks keep coming, so the block backs up
      if (ph_no == 1) begin
        holds_asked++;
        src_gap_max = 0;
        run_sequence(mlss_pkg::MODE_LOCK, 1'b1);
        src_gap_max = 10;
      end

      repeat (n_seq) begin
        cmd = ($urandom_range(0, 1) != 0) ? mlss_pkg::MODE_LOCK : mlss_pkg::MODE_UNLOCK;
        run_sequence(cmd, ($urandom_range(0, 5) != 0));
        // a little noise between sequences
        repeat ($urandom_range(0, 2))
          send_tick(mlss_pkg::mode_e'($urandom_range(0, 3)), 12'($urandom), 1'($urandom));
        if (ph_no == 5) drain();
      end
      ph_no++;
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Ran %0d sample ticks through %0d register settings.", ticks_sent, settings);
    $display("Saw %0d finished sequences and %0d stall detections.", seq_done, stall_cnt);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
